// File: src/hdlcd_pkg.sv
// Package: shared types, constants, CRC helper and payload-count helper for the HDLC deframer.
`default_nettype none
package hdlcd_pkg;

	localparam logic [7:0]  FLAG_OCTET   = 8'h7E;
	localparam logic [7:0]  ESCAPE_OCTET = 8'h7D;
	localparam logic [7:0]  FLIP_MASK    = 8'h20;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] MAX_LEN_RST  = 16'd512;

	typedef enum logic [2:0] {
		ST_GOOD      = 3'd0,
		ST_CRC_ERROR = 3'd1,
		ST_ABORTED   = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic        esc;
		logic [15:0] pos;
		logic [15:0] crc;
		logic [7:0]  held0;  // older octet
		logic [7:0]  held1;
	} state_t;

	typedef struct packed {
		logic        has;
		logic [7:0]  pay;
		logic        valid;
		logic        fend;
		status_t     status;
		logic [15:0] len;
	} result_t;

	// Reflected CRC-16-CCITT (0x8408), one octet, table-free form.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] octet);
		logic [7:0] d;
		begin
			d = octet ^ crc[7:0];
			d = d ^ {d[3:0], 4'b0000};
			crc_fold = {d, crc[15:8]} ^ {12'd0, d[7:4]} ^ {5'd0, d, 3'b000};
		end
	endfunction

	// Payload octets in a frame of count octets: the two check octets are held back.
	function automatic logic [15:0] payload_count(input logic [15:0] count);
		begin
			payload_count = (count >= 16'd2) ? count - 16'd2 : 16'd0;
		end
	endfunction

endpackage
`default_nettype wire

// File: src/hdlcd_channels.sv
// Interfaces: input octet channel, result channel and configuration write channel.
`default_nettype none
interface hdlcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hdlcd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic        frame_end;
	logic [2:0]  end_status;
	logic [15:0] payload_length;
	modport source (output valid, output payload_byte, output byte_valid, output frame_end,
		output end_status, output payload_length, input ready);
	modport sink (input valid, input payload_byte, input byte_valid, input frame_end,
		input end_status, input payload_length, output ready);
endinterface

interface hdlcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_frame_length;
	modport source (output valid, output max_frame_length, input ready);
	modport sink (input valid, input max_frame_length, output ready);
endinterface
`default_nettype wire

// File: src/hdlcd_step.sv
// Per-octet deframing logic: unescape, delay line, CRC fold and frame-end status.
`default_nettype none
module hdlcd_step (
	input  wire logic [7:0]       octet,
	input  wire logic [15:0]      max_len,
	input  wire hdlcd_pkg::state_t cur,
	output hdlcd_pkg::state_t     nxt,
	output hdlcd_pkg::result_t    res
);

	logic        is_flag;
	logic        esc_start;
	logic [7:0]  data;
	logic [15:0] pos_inc;
	logic        full;

	assign is_flag   = (octet == hdlcd_pkg::FLAG_OCTET);
	assign esc_start = !is_flag && !cur.esc && (octet == hdlcd_pkg::ESCAPE_OCTET);
	assign data      = cur.esc ? (octet ^ hdlcd_pkg::FLIP_MASK) : octet;
	// pos is cleared once it reaches max_len (<= 65535), so it never passes 65534
	assign pos_inc   = cur.pos + 16'd1;
	assign full      = (pos_inc >= max_len);

	always_comb begin
		nxt        = cur;
		res.pay    = 8'd0;
		res.valid  = 1'b0;
		res.fend   = 1'b0;
		res.status = hdlcd_pkg::ST_GOOD;
		res.len    = 16'd0;
		if (is_flag) begin
			if (cur.esc || (cur.pos != 16'd0)) begin
				res.fend = 1'b1;
				res.len  = hdlcd_pkg::payload_count(cur.pos);
				if (cur.esc) begin
					res.status = hdlcd_pkg::ST_ABORTED;
				end else if (cur.pos < 16'd2) begin
					res.status = hdlcd_pkg::ST_TOO_SHORT;
				end else if ({cur.held1, cur.held0} == cur.crc) begin
					res.status = hdlcd_pkg::ST_GOOD;
				end else begin
					res.status = hdlcd_pkg::ST_CRC_ERROR;
				end
			end
			nxt.esc = 1'b0;
			nxt.pos = 16'd0;
			nxt.crc = hdlcd_pkg::CRC_INIT;
		end else if (esc_start) begin
			nxt.esc = 1'b1;
		end else begin
			nxt.esc = 1'b0;
			if (cur.pos >= 16'd2) begin
				res.pay   = cur.held0;
				res.valid = 1'b1;
				nxt.crc   = hdlcd_pkg::crc_fold(cur.crc, cur.held0);
			end
			nxt.held0 = cur.held1;
			nxt.held1 = data;
			nxt.pos   = pos_inc;
			if (full) begin
				res.fend   = 1'b1;
				res.status = hdlcd_pkg::ST_OVERFLOW;
				res.len    = hdlcd_pkg::payload_count(pos_inc);
				nxt.pos    = 16'd0;
				nxt.crc    = hdlcd_pkg::CRC_INIT;
			end
		end
		res.has = res.valid || res.fend;
	end

endmodule
`default_nettype wire

// File: src/hdlc_async_deframer_unit.sv
// An accepted octet is held in the input reg (s1); its result is then stored in the result reg.
// Throughput: one octet per cycle while the result reg is free or drained; state and CRC update
// in a single pass per octet. Octets that cause no result (escapes, empty flags) just update state.
// Reset (arst_n low, async): frame state cleared, CRC = 0xFFFF, max_frame_length = 512,
// both pipeline registers empty. The two held octets have no reset.
`default_nettype none
module hdlc_async_deframer_unit (
	input wire logic   clk,
	input wire logic   arst_n,
	hdlcd_in_if.sink   in_ch,
	hdlcd_out_if.source out_ch,
	hdlcd_cfg_if.sink  cfg
);

	logic               valid_s1;
	logic [7:0]         rx_s1;
	logic [15:0]        max_len_q;
	logic               esc_q;
	logic [15:0]        pos_q;
	logic [15:0]        crc_q;
	logic [7:0]         held0_q;
	logic [7:0]         held1_q;
	logic               out_valid_q;
	hdlcd_pkg::result_t out_q;
	hdlcd_pkg::state_t  cur;
	hdlcd_pkg::state_t  nxt;
	hdlcd_pkg::result_t res;
	logic               advance;
	logic               fire;

	assign cur = '{esc: esc_q, pos: pos_q, crc: crc_q, held0: held0_q, held1: held1_q};

	hdlcd_step u_step (
		.octet   (rx_s1),
		.max_len (max_len_q),
		.cur     (cur),
		.nxt     (nxt),
		.res     (res)
	);

	// s1 may move on when the result register is free or being drained this cycle
	assign advance     = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= hdlcd_pkg::MAX_LEN_RST;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_frame_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			rx_s1 <= in_ch.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			pos_q <= 16'd0;
			crc_q <= hdlcd_pkg::CRC_INIT;
		end else if (fire) begin
			esc_q <= nxt.esc;
			pos_q <= nxt.pos;
			crc_q <= nxt.crc;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held0_q <= nxt.held0;
			held1_q <= nxt.held1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.has) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.has) begin
			out_q <= res;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.payload_byte   = out_q.pay;
	assign out_ch.byte_valid     = out_q.valid;
	assign out_ch.frame_end      = out_q.fend;
	assign out_ch.end_status     = out_q.status;
	assign out_ch.payload_length = out_q.len;

endmodule
`default_nettype wire
